### rtl/core/ll1pp_pkg.sv
// Shared types and codes for the LL(1) predictive parser.
package ll1pp_pkg;

  localparam int SYM_W     = 8;
  localparam int RIGHT_W   = 64;
  localparam int LEN_W     = 4;
  localparam int RIGHT_MAX = 8;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_SYMBOL = 2'd2;

  localparam logic [2:0] ST_READY    = 3'd0;
  localparam logic [2:0] ST_CONSUMED = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic KIND_RULE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic CFG_START_SYMBOL = 1'b0;
  localparam logic CFG_END_MARKER   = 1'b1;

  typedef struct packed {
    logic [SYM_W-1:0]   left;
    logic [RIGHT_W-1:0] right;
    logic [LEN_W-1:0]   len;
  } rule_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START2,
    S_TOP,
    S_SCAN,
    S_CHK,
    S_PUSH,
    S_RULE,
    S_EMIT
  } state_t;

endpackage

### rtl/core/ll1pp_rules.sv
// Rule store: left symbol and right side in memory, lengths in resettable flops.
module ll1pp_rules #(
  parameter int RULE_SLOTS = 16,
  localparam int RW = $clog2(RULE_SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [RW-1:0]       wr_addr,
  input  ll1pp_pkg::rule_ent_t wr_ent,
  input  logic [RW-1:0]       rd_addr,
  output ll1pp_pkg::rule_ent_t rd_ent
);
  import ll1pp_pkg::*;

  logic [SYM_W-1:0]   left_mem  [RULE_SLOTS];
  logic [RIGHT_W-1:0] right_mem [RULE_SLOTS];
  logic [LEN_W-1:0]   len_r     [RULE_SLOTS];

  logic [SYM_W-1:0]   rd_left_r;
  logic [RIGHT_W-1:0] rd_right_r;
  logic [LEN_W-1:0]   rd_len_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= wr_ent.left;
      right_mem[wr_addr] <= wr_ent.right;
    end
    rd_left_r  <= left_mem[rd_addr];
    rd_right_r <= right_mem[rd_addr];
    rd_len_r   <= len_r[rd_addr];
  end

  // Zero length marks an empty slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        len_r[i] <= '0;
      end
    end else if (wr_en) begin
      len_r[wr_addr] <= wr_ent.len;
    end
  end

  always_comb begin
    rd_ent.left  = rd_left_r;
    rd_ent.right = rd_right_r;
    rd_ent.len   = rd_len_r;
  end

endmodule

### rtl/core/ll1pp_stack.sv
// Parse stack memory: one write port, one registered read port.
module ll1pp_stack #(
  parameter int STACK_DEPTH = 32,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ll1pp_pkg::SYM_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [ll1pp_pkg::SYM_W-1:0] rd_data
);
  import ll1pp_pkg::*;

  logic [SYM_W-1:0] mem [STACK_DEPTH];
  logic [SYM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/ll1_predictive_parser.sv
// Top level of the LL(1) predictive parser: sequencer, compare unit and result register.
// Load: straight to the status result; start: second stack write, then status; symbol with a
// direct match: top read and pop, then status. Expansion: top read, slot scan (one rule read per
// cycle), overflow check, pushes (one push per cycle), rule report, then status.
// One item at a time: in_stall stays high from acceptance until its last result is loaded.
// Reset (rst_n low, synchronous): rule lengths cleared, stack empty, no word active,
// start_symbol = 83, end_marker = 35, no result pending.
module ll1_predictive_parser #(
  parameter int RULE_SLOTS  = 16,
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_rule_number,
  input  logic [7:0]  in_rule_left,
  input  logic [3:0]  in_rule_length,
  input  logic [63:0] in_rule_right,
  input  logic [7:0]  in_symbol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [3:0]  out_applied_rule,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import ll1pp_pkg::*;

  localparam int RW = $clog2(RULE_SLOTS);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [SYM_W-1:0]   start_r, end_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic               done_r, done_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [SYM_W-1:0]   top_r, top_nxt;
  logic [RW-1:0]      scan_r, scan_nxt;
  logic [RW-1:0]      idx_q_r, idx_q_nxt;
  logic               pend_r, pend_nxt;
  logic [RW-1:0]      sel_idx_r, sel_idx_nxt;
  logic [RIGHT_W-1:0] sel_right_r, sel_right_nxt;
  logic [LEN_W-1:0]   sel_len_r, sel_len_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [2:0]         fin_r, fin_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [3:0] out_rule_r, out_rule_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic       out_last_r, out_last_nxt;

  logic             in_acc;
  logic             out_free;
  logic             slot_ok;
  logic [LEN_W-1:0] len_clamp;
  logic             rule_we;
  rule_ent_t        rule_wr, rule_rd;
  logic             stk_we;
  logic [AW-1:0]    stk_waddr;
  logic [SYM_W-1:0] stk_wdata, stk_rd;
  logic [CW-1:0]    base;
  logic [CW:0]      need;
  logic             hit;
  logic             last_slot;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign slot_ok   = (32'(in_rule_number) < RULE_SLOTS);
  assign len_clamp = (32'(in_rule_length) > RIGHT_MAX) ? LEN_W'(RIGHT_MAX) : in_rule_length;
  assign rule_we   = in_acc && (in_operation == OP_LOAD) && slot_ok;

  always_comb begin
    rule_wr.left  = in_rule_left;
    rule_wr.right = in_rule_right;
    rule_wr.len   = len_clamp;
  end

  ll1pp_rules #(.RULE_SLOTS(RULE_SLOTS)) u_rules (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rule_we),
    .wr_addr (RW'(in_rule_number)),
    .wr_ent  (rule_wr),
    .rd_addr (scan_r),
    .rd_ent  (rule_rd)
  );

  ll1pp_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (AW'(count_r - CW'(1))),
    .rd_data (stk_rd)
  );

  // Compare unit shared by every slot of the scan.
  assign hit = pend_r && (rule_rd.len != '0) && (rule_rd.left == top_r) &&
               (rule_rd.right[SYM_W-1:0] == sym_r);
  assign last_slot = (idx_q_r == RW'(RULE_SLOTS - 1));
  assign base = count_r - CW'(1);
  assign need = (CW+1)'(base) + (CW+1)'(sel_len_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_operation)
            OP_LOAD:   state_nxt = S_EMIT;
            OP_START:  state_nxt = S_START2;
            OP_SYMBOL: state_nxt = (done_r || count_r == '0) ? S_EMIT : S_TOP;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_START2: state_nxt = S_EMIT;
      S_TOP: begin
        if (stk_rd == end_r || stk_rd == sym_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_CHK;
        end else if (pend_r && last_slot) begin
          state_nxt = S_EMIT;
        end
      end
      S_CHK:  state_nxt = (need > (CW+1)'(STACK_DEPTH)) ? S_EMIT : S_PUSH;
      S_PUSH: state_nxt = (pos_r == 3'd0) ? S_RULE : S_PUSH;
      S_RULE: state_nxt = out_free ? S_EMIT : S_RULE;
      S_EMIT: state_nxt = out_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    count_nxt      = count_r;
    done_nxt       = done_r;
    sym_nxt        = sym_r;
    top_nxt        = top_r;
    scan_nxt       = scan_r;
    idx_q_nxt      = idx_q_r;
    pend_nxt       = pend_r;
    sel_idx_nxt    = sel_idx_r;
    sel_right_nxt  = sel_right_r;
    sel_len_nxt    = sel_len_r;
    wp_nxt         = wp_r;
    pos_nxt        = pos_r;
    fin_nxt        = fin_r;
    stk_we         = 1'b0;
    stk_waddr      = wp_r;
    stk_wdata      = sel_right_r[{pos_r, 3'b000} +: SYM_W];
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_rule_nxt   = out_rule_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sym_nxt = in_symbol;
          fin_nxt = ST_READY;
          if (in_operation == OP_START) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = end_r;
          end
          if (in_operation == OP_SYMBOL && (done_r || count_r == '0)) begin
            fin_nxt  = ST_REJECTED;
            done_nxt = 1'b1;
          end
        end
      end
      S_START2: begin
        stk_we    = 1'b1;
        stk_waddr = AW'(1);
        stk_wdata = start_r;
        count_nxt = CW'(2);
        done_nxt  = 1'b0;
      end
      S_TOP: begin
        top_nxt  = stk_rd;
        scan_nxt = '0;
        pend_nxt = 1'b0;
        if (stk_rd == end_r) begin
          fin_nxt  = (sym_r == end_r) ? ST_ACCEPTED : ST_REJECTED;
          done_nxt = 1'b1;
        end else if (stk_rd == sym_r) begin
          // direct match: pop
          count_nxt = count_r - CW'(1);
          fin_nxt   = ST_CONSUMED;
        end
      end
      S_SCAN: begin
        if (hit) begin
          sel_idx_nxt   = idx_q_r;
          sel_right_nxt = rule_rd.right;
          sel_len_nxt   = rule_rd.len;
        end else if (pend_r && last_slot) begin
          fin_nxt  = ST_REJECTED;
          done_nxt = 1'b1;
        end else begin
          // issue next slot read; compare follows in the next cycle
          idx_q_nxt = scan_r;
          pend_nxt  = 1'b1;
          scan_nxt  = scan_r + RW'(1);
        end
      end
      S_CHK: begin
        if (need > (CW+1)'(STACK_DEPTH)) begin
          fin_nxt  = ST_OVERFLOW;
          done_nxt = 1'b1;
        end else begin
          count_nxt = CW'(need);
          wp_nxt    = AW'(base);
          pos_nxt   = 3'(sel_len_r - LEN_W'(1));
        end
      end
      S_PUSH: begin
        // last right-side symbol goes deepest
        stk_we  = 1'b1;
        wp_nxt  = wp_r + AW'(1);
        pos_nxt = pos_r - 3'd1;
      end
      S_RULE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_RULE;
          out_rule_nxt   = 4'(sel_idx_r);
          out_status_nxt = ST_READY;
          out_last_nxt   = 1'b0;
          if (sym_r == end_r) begin
            fin_nxt  = ST_ACCEPTED;
            done_nxt = 1'b1;
          end else begin
            count_nxt = count_r - CW'(1);
            fin_nxt   = ST_CONSUMED;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_rule_nxt   = 4'd0;
          out_status_nxt = fin_r;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
        stk_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 8'd83;
      end_r       <= 8'd35;
      count_r     <= '0;
      done_r      <= 1'b1;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_SYMBOL: start_r <= cfg_wdata;
          CFG_END_MARKER:   end_r   <= cfg_wdata;
          default:          start_r <= start_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    top_r        <= top_nxt;
    scan_r       <= scan_nxt;
    idx_q_r      <= idx_q_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_right_r  <= sel_right_nxt;
    sel_len_r    <= sel_len_nxt;
    wp_r         <= wp_nxt;
    pos_r        <= pos_nxt;
    fin_r        <= fin_nxt;
    out_kind_r   <= out_kind_nxt;
    out_rule_r   <= out_rule_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_applied_rule = out_rule_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

### rtl/core/ll1pp_checker.sv
// Port-level checker for the LL(1) predictive parser, bound to the top level.
module ll1pp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [2:0] out_status,
  input logic       out_last
);
  import ll1pp_pkg::*;

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  // A rule report is never the last beat and carries ST_READY; a status beat always follows it.
  a_rule_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_RULE |-> !out_last && out_status == ST_READY)
    else $error("rule report marked last or carries a status");

  a_rule_then_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_RULE && !out_stall |=> out_valid && out_kind == KIND_STATUS)
    else $error("final status of an expansion not presented after the rule beat");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_operation == OP_LOAD || in_operation == OP_START || in_operation == OP_SYMBOL)
    |=> in_stall)
    else $error("input not held off while an item is worked");

endmodule

bind ll1_predictive_parser ll1pp_checker u_ll1pp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_kind     (out_kind),
  .out_status   (out_status),
  .out_last     (out_last)
);
